@@ hw/rtl/pmmd_pkg.sv @@
package pmmd_pkg;

    localparam int REGION_COUNT_DEF = 4;
    localparam int PAGE_COUNT_DEF   = 256;
    localparam int ROM_BYTES_DEF    = 16384;
    localparam int SPAN_W           = 33;
    localparam int ACTION_W         = 18;
    localparam int CFG_IDX_W        = 3;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_FILL   = 2'd1;
    localparam logic [1:0] KIND_MIRROR = 2'd2;
    localparam logic [1:0] KIND_ROM    = 2'd3;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] SRV_RAM  = 2'd0;
    localparam logic [1:0] SRV_FILL = 2'd1;
    localparam logic [1:0] SRV_ROM  = 2'd2;
    localparam logic [1:0] SRV_NONE = 2'd3;

    localparam logic [2:0] NO_OWNER = 3'd4;

endpackage

@@ hw/rtl/paged_memory_map_decoder_top.sv @@
// Paged memory map decoder. One request at a time. A read of RAM or ROM steps through
// owner lookup, decode, execute, memory read and result; any other request skips the
// memory read. A mirror hit adds a second owner lookup and decode. The first write to an
// unallocated page adds a zero-fill sweep of one byte per cycle, set by the single RAM
// write port, then the write itself. A result waiting at the output holds the block in
// its result state. The page owner table is rebuilt from the region registers after
// reset and after each configuration write, a check pass and a mark pass per region,
// with no request taken.
module paged_memory_map_decoder_top #(
    parameter int REGION_COUNT = pmmd_pkg::REGION_COUNT_DEF,
    parameter int ROM_BYTES    = pmmd_pkg::ROM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [pmmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pmmd_pkg::SPAN_W-1:0]    i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // kind[1:0], address[17:2], write_data[25:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // read_data[7:0], served_by[9:8]
);
    localparam int RA_W = $clog2(ROM_BYTES);

    localparam logic [3:0] S_BUILD = 4'd0, S_IDLE = 4'd1, S_DEC1 = 4'd2,
        S_DEC2 = 4'd3, S_EXEC = 4'd4, S_FILL = 4'd5, S_RDWAIT = 4'd6,
        S_OUT = 4'd7, S_DWAIT = 4'd8;

    logic [32:0] r_span [4];
    logic [17:0] r_act [4];
    logic [2:0]  r_owner [256];
    logic [2:0]  r_own_q;
    logic [255:0] r_alloc;
    logic [7:0]  ram [65536];
    logic [7:0]  rom [ROM_BYTES];
    logic [7:0]  r_ram_q, r_rom_q;

    logic [3:0]  r_state;
    logic [8:0]  r_cnt;
    logic [2:0]  r_reg;
    logic        r_clash;
    logic        r_chk;
    logic [1:0]  r_kind;
    logic [15:0] r_addr;
    logic [7:0]  r_wd;
    logic [2:0]  r_rg;
    logic        r_romsel;
    logic [7:0]  r_rd;
    logic [1:0]  r_srv;
    logic [7:0]  r_out_rd;
    logic [1:0]  r_out_srv;
    logic        r_valid;

    // claim build: per region, pass 0 checks (for region 0 it clears the table), pass 1 marks
    logic        r_pass;
    logic [9:0]  w_n;
    logic [7:0]  w_pg;
    logic        w_act_ok;
    always_comb begin
        w_n = 10'((18'(r_span[r_reg[1:0]][32:16]) + 18'd255) >> 8);
        w_pg = 8'(r_span[r_reg[1:0]][15:8] + r_cnt[7:0]);
        w_act_ok = (r_act[r_reg[1:0]][17:16] != pmmd_pkg::KIND_NONE) &&
                   (w_n <= 10'd256) && (32'(r_reg) < REGION_COUNT);
    end

    logic [7:0]  w_own_ra;
    always_comb begin
        if (r_state == S_BUILD) w_own_ra = w_pg;
        else if (r_state == S_IDLE) w_own_ra = s_axis_tdata[17:10];
        else w_own_ra = r_addr[15:8];
    end

    function automatic logic inside_f(input logic [32:0] sp, input logic [15:0] a);
        logic [16:0] e;
        e = 17'(sp[15:0]) + sp[32:16];
        return (a >= sp[15:0]) && (17'(a) < e);
    endfunction

    logic [2:0]  w_o;
    logic        w_hit;
    assign w_o = r_own_q;
    assign w_hit = (w_o != pmmd_pkg::NO_OWNER) && inside_f(r_span[w_o[1:0]], r_addr);

    logic [15:0] w_off;
    assign w_off = r_addr - r_span[r_rg[1:0]][15:0];

    logic        w_out_load;
    assign w_out_load = (r_state == S_OUT) && !i_cfg_we && (!r_valid || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata = {6'd0, r_out_srv, r_out_rd};

    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL) ram[{r_addr[15:8], r_cnt[7:0]}] <= 8'd0;
        else if (r_state == S_EXEC && r_kind == pmmd_pkg::OP_WRITE &&
                 r_rg == pmmd_pkg::NO_OWNER && r_alloc[r_addr[15:8]])
            ram[r_addr] <= r_wd;
        r_ram_q <= ram[r_addr];
        if (r_state == S_EXEC && r_kind == pmmd_pkg::OP_LOAD && 17'(r_addr) < 17'(ROM_BYTES))
            rom[r_addr[RA_W-1:0]] <= r_wd;
        r_rom_q <= rom[w_off[RA_W-1:0]];
        if (r_state == S_BUILD) begin
            if (r_reg == 3'd0 && !r_pass) r_owner[r_cnt[7:0]] <= pmmd_pkg::NO_OWNER;
            else if (r_pass && w_act_ok && !r_clash && 10'(r_cnt) < w_n)
                r_owner[w_pg] <= r_reg;
        end
        r_own_q <= r_owner[w_own_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_span[i] <= '0;
                r_act[i] <= '0;
            end
            r_alloc <= '0;
            r_state <= S_BUILD;
            r_cnt <= '0;
            r_reg <= '0;
            r_pass <= 1'b0;
            r_clash <= 1'b0;
            r_chk <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (w_out_load) r_valid <= 1'b1;
            else if (m_axis_tready) r_valid <= 1'b0;
            r_chk <= (r_state == S_BUILD) && !i_cfg_we && !r_pass && r_reg != 3'd0 &&
                     !r_cnt[8] && (10'(r_cnt) < w_n);
            if (i_cfg_we) begin
                if (i_cfg_index[0]) r_act[i_cfg_index[2:1]] <= i_cfg_data[17:0];
                else r_span[i_cfg_index[2:1]] <= i_cfg_data;
                r_state <= S_BUILD;
                r_cnt <= '0;
                r_reg <= '0;
                r_pass <= 1'b0;
                r_clash <= 1'b0;
            end else begin
                unique case (r_state)
                    S_BUILD: begin
                        // owner reads are registered, so the check pass runs past the last page
                        if (r_chk && r_own_q != pmmd_pkg::NO_OWNER) r_clash <= 1'b1;
                        if (!r_pass && r_cnt == 9'd256) begin
                            r_cnt <= '0;
                            r_pass <= 1'b1;
                        end else if (r_pass && r_cnt == 9'd255) begin
                            r_cnt <= '0;
                            r_pass <= 1'b0;
                            r_clash <= 1'b0;
                            if (r_reg == 3'd3) r_state <= S_IDLE;
                            else r_reg <= r_reg + 3'd1;
                        end else r_cnt <= r_cnt + 9'd1;
                    end
                    S_IDLE: begin
                        if (s_axis_tvalid) begin
                            r_kind <= s_axis_tdata[1:0];
                            r_addr <= s_axis_tdata[17:2];
                            r_wd <= s_axis_tdata[25:18];
                            r_rg <= pmmd_pkg::NO_OWNER;
                            r_state <= S_DEC1;
                        end
                    end
                    S_DEC1: begin
                        if (r_kind[1]) r_state <= S_EXEC;
                        else if (w_hit) begin
                            r_rg <= w_o;
                            if (r_act[w_o[1:0]][17:16] == pmmd_pkg::KIND_MIRROR) begin
                                r_addr <= r_act[w_o[1:0]][15:0] + r_addr -
                                          r_span[w_o[1:0]][15:0];
                                r_state <= S_DWAIT;
                            end else r_state <= S_EXEC;
                        end else r_state <= S_EXEC;
                    end
                    S_DWAIT: begin
                        r_state <= S_DEC2;
                    end
                    S_DEC2: begin
                        if (w_hit && r_act[w_o[1:0]][17:16] != pmmd_pkg::KIND_MIRROR)
                            r_rg <= w_o;
                        else r_rg <= pmmd_pkg::NO_OWNER;
                        r_state <= S_EXEC;
                    end
                    S_EXEC: begin
                        if (r_kind[1]) begin
                            if (r_kind == pmmd_pkg::OP_CLEAR) r_alloc <= '0;
                            r_rd <= '0;
                            r_srv <= pmmd_pkg::SRV_NONE;
                            r_romsel <= 1'b0;
                            r_state <= S_OUT;
                        end else if (r_rg != pmmd_pkg::NO_OWNER &&
                                     r_act[r_rg[1:0]][17:16] == pmmd_pkg::KIND_FILL) begin
                            r_srv <= pmmd_pkg::SRV_FILL;
                            r_romsel <= 1'b0;
                            r_rd <= (r_kind == pmmd_pkg::OP_READ) ?
                                    r_act[r_rg[1:0]][7:0] : 8'd0;
                            r_state <= S_OUT;
                        end else if (r_rg != pmmd_pkg::NO_OWNER) begin
                            r_srv <= pmmd_pkg::SRV_ROM;
                            r_romsel <= 1'b1;
                            r_rd <= '0;
                            r_state <= (r_kind == pmmd_pkg::OP_READ) ? S_RDWAIT : S_OUT;
                        end else begin
                            r_srv <= pmmd_pkg::SRV_RAM;
                            r_romsel <= 1'b0;
                            r_rd <= '0;
                            if (r_kind == pmmd_pkg::OP_WRITE && !r_alloc[r_addr[15:8]]) begin
                                r_cnt <= '0;
                                r_state <= S_FILL;
                            end else
                                r_state <= (r_kind == pmmd_pkg::OP_READ) ? S_RDWAIT : S_OUT;
                        end
                    end
                    S_FILL: begin
                        if (r_cnt == 9'd255) begin
                            r_alloc[r_addr[15:8]] <= 1'b1;
                            r_cnt <= '0;
                            r_state <= S_EXEC;
                        end else r_cnt <= r_cnt + 9'd1;
                    end
                    S_RDWAIT: begin
                        if (r_romsel) begin
                            if (17'(w_off) < 17'(r_act[r_rg[1:0]][15:0]) &&
                                17'(w_off) < 17'(ROM_BYTES))
                                r_rd <= r_rom_q;
                        end else if (r_alloc[r_addr[15:8]]) r_rd <= r_ram_q;
                        r_state <= S_OUT;
                    end
                    S_OUT: begin
                        if (!r_valid || m_axis_tready) begin
                            r_out_rd <= r_rd;
                            r_out_srv <= r_srv;
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end
endmodule

@@ bench/tb_paged_memory_map_decoder_top.sv @@
module tb_paged_memory_map_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 300;

    class decoder_scoreboard;
        int          region_count;
        bit [32:0]   span[4];
        bit [17:0]   action[4];
        bit [7:0]    ram[65536];
        bit          alloc[256];
        bit [7:0]    rom[16384];
        bit          rom_set[16384];
        int          owner[256];
        bit [7:0]    exp_data[$];
        bit [1:0]    exp_srv[$];
        int          errors;

        function new(int rc);
            region_count = rc;
            errors = 0;
        endfunction

        function int base_of(int r);
            return span[r][15:0];
        endfunction

        function int len_of(int r);
            return span[r][32:16];
        endfunction

        function bit [1:0] kind_of(int r);
            return action[r][17:16];
        endfunction

        function int arg_of(int r);
            return action[r][15:0];
        endfunction

        function void set_reg(int idx, bit [32:0] v);
            if (idx % 2 == 0) begin
                span[idx / 2] = v;
            end else begin
                action[idx / 2] = v[17:0];
            end
        endfunction

        function void claim_pages();
            int  n;
            int  first;
            bit  clash;
            foreach (owner[p]) owner[p] = -1;
            for (int r = 0; r < region_count; r++) begin
                if (kind_of(r) == pmmd_pkg::KIND_NONE) continue;
                n = (len_of(r) + 255) / 256;
                if (n > 256) continue;
                first = base_of(r) >> 8;
                clash = 0;
                for (int i = 0; i < n; i++)
                    if (owner[(first + i) & 255] != -1) clash = 1;
                if (clash) continue;
                for (int i = 0; i < n; i++) owner[(first + i) & 255] = r;
            end
        endfunction

        function bit covers(int r, int a);
            return a >= base_of(r) && a < base_of(r) + len_of(r);
        endfunction

        // region serving address a (rewritten for a mirror), -1 for ram
        function int route(inout int a);
            int r;
            r = owner[(a >> 8) & 255];
            if (r < 0 || !covers(r, a)) return -1;
            if (kind_of(r) == pmmd_pkg::KIND_MIRROR) begin
                a = (arg_of(r) + a - base_of(r)) & 16'hFFFF;
                r = owner[(a >> 8) & 255];
                if (r < 0 || !covers(r, a)) return -1;
            end
            if (kind_of(r) == pmmd_pkg::KIND_MIRROR) return -1;
            return r;
        endfunction

        // rom image offset a read at addr would fetch, -1 if none
        function int rom_index(int addr);
            int a;
            int r;
            int off;
            a = addr;
            claim_pages();
            r = route(a);
            if (r < 0 || kind_of(r) != pmmd_pkg::KIND_ROM) return -1;
            off = (a - base_of(r)) & 16'hFFFF;
            if (off < arg_of(r) && off < 16384) return off;
            return -1;
        endfunction

        function void note_request(logic [1:0] k, logic [15:0] addr, logic [7:0] d);
            int        a;
            int        r;
            int        off;
            int        p;
            bit [7:0]  rd;
            bit [1:0]  srv;
            a = addr;
            rd = 8'h00;
            srv = pmmd_pkg::SRV_NONE;
            if (k == pmmd_pkg::OP_READ || k == pmmd_pkg::OP_WRITE) begin
                claim_pages();
                r = route(a);
                if (r >= 0 && kind_of(r) == pmmd_pkg::KIND_FILL) begin
                    srv = pmmd_pkg::SRV_FILL;
                    if (k == pmmd_pkg::OP_READ) rd = 8'(arg_of(r));
                end else if (r >= 0 && kind_of(r) == pmmd_pkg::KIND_ROM) begin
                    srv = pmmd_pkg::SRV_ROM;
                    if (k == pmmd_pkg::OP_READ) begin
                        off = (a - base_of(r)) & 16'hFFFF;
                        if (off < arg_of(r) && off < 16384) rd = rom[off];
                    end
                end else begin
                    srv = pmmd_pkg::SRV_RAM;
                    p = (a >> 8) & 255;
                    if (k == pmmd_pkg::OP_READ) begin
                        if (alloc[p]) rd = ram[a];
                    end else begin
                        if (!alloc[p]) begin
                            for (int i = 0; i < 256; i++) ram[p * 256 + i] = 8'h00;
                            alloc[p] = 1;
                        end
                        ram[a] = d;
                    end
                end
            end else if (k == pmmd_pkg::OP_LOAD) begin
                if (addr < 16384) begin
                    rom[addr] = d;
                    rom_set[addr] = 1;
                end
            end else begin
                foreach (alloc[i]) alloc[i] = 0;
            end
            exp_data.push_back(rd);
            exp_srv.push_back(srv);
        endfunction

        function void check_result(logic [15:0] t);
            bit [7:0] rd;
            bit [1:0] srv;
            if (exp_data.size() == 0) begin
                $display("%0t: result with no request pending, got %h", $time, t);
                errors++;
                return;
            end
            rd = exp_data.pop_front();
            srv = exp_srv.pop_front();
            if (t[7:0] !== rd) begin
                $display("%0t: read_data expected %h actual %h", $time, rd, t[7:0]);
                errors++;
            end
            if (t[9:8] !== srv) begin
                $display("%0t: served_by expected %0d actual %0d", $time, srv, t[9:8]);
                errors++;
            end
        endfunction

        function int pending();
            return exp_data.size();
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [pmmd_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [pmmd_pkg::SPAN_W-1:0]    i_cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [31:0]                    s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [15:0]                    m_axis_tdata;

    decoder_scoreboard sb;
    bit                steady;
    int                cycles = 0;

    paged_memory_map_decoder_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 12);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(int idx, logic [32:0] v);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= 3'(idx);
        i_cfg_data  <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic set_region(int r, logic [15:0] base, logic [16:0] len,
                              logic [1:0] kind, logic [15:0] arg);
        write_reg(2 * r, {len, base});
        write_reg(2 * r + 1, {15'd0, kind, arg});
    endtask

    task automatic issue(logic [1:0] k, logic [15:0] a, logic [7:0] d);
        int off;
        // never fetch a rom image byte that was not loaded: load it instead
        if (k == pmmd_pkg::OP_READ) begin
            off = sb.rom_index(a);
            if (off >= 0 && !sb.rom_set[off]) begin
                k = pmmd_pkg::OP_LOAD;
                a = 16'(off);
            end
        end
        if (!steady) begin
            while ($urandom_range(99) < 12) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, d, a, k};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(k, a, d);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_addr();
        int r;
        int reach;
        r = $urandom_range(3);
        case ($urandom_range(3))
            0, 1: begin
                reach = sb.len_of(r) > 16'h1000 ? 16'h1000 : sb.len_of(r);
                return 16'(sb.base_of(r) + $urandom_range(0, reach + 16));
            end
            2: begin
                return 16'(sb.arg_of(r) + $urandom_range(0, 16'h0200));
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    task automatic random_batch(int n);
        logic [1:0]  k;
        logic [15:0] a;
        int          sel;
        repeat (n) begin
            sel = $urandom_range(99);
            if (sel < 45) k = pmmd_pkg::OP_READ;
            else if (sel < 80) k = pmmd_pkg::OP_WRITE;
            else if (sel < 97) k = pmmd_pkg::OP_LOAD;
            else k = pmmd_pkg::OP_CLEAR;
            a = pick_addr();
            if (k == pmmd_pkg::OP_LOAD && $urandom_range(3) != 0)
                a = 16'($urandom_range(0, 16'h0FFF));
            issue(k, a, 8'($urandom));
        end
    endtask

    task automatic random_config();
        logic [16:0] len;
        logic [1:0]  kind;
        logic [15:0] arg;
        for (int r = 0; r < 4; r++) begin
            case ($urandom_range(9))
                0: len = 17'h1FFFF;
                1: len = 17'h10000;
                2: len = 17'd0;
                default: len = 17'($urandom_range(1, 16'h1800));
            endcase
            kind = 2'($urandom_range(3));
            arg = (kind == pmmd_pkg::KIND_ROM) ? 16'($urandom_range(0, 16'h4800)) :
                                                 16'($urandom);
            set_region(r, 16'($urandom), len, kind, arg);
        end
    endtask

    initial begin
        sb = new(pmmd_pkg::REGION_COUNT_DEF);
        steady = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all ram: unallocated reads, zero-fill, clear, out-of-range loads
        issue(pmmd_pkg::OP_READ,  16'h0000, 8'h00);
        issue(pmmd_pkg::OP_WRITE, 16'h0000, 8'hFF);
        issue(pmmd_pkg::OP_READ,  16'h0000, 8'h00);
        issue(pmmd_pkg::OP_READ,  16'h00FF, 8'h00);
        issue(pmmd_pkg::OP_WRITE, 16'hFFFF, 8'h00);
        issue(pmmd_pkg::OP_READ,  16'hFFFF, 8'hFF);
        issue(pmmd_pkg::OP_LOAD,  16'h3FFF, 8'hAA);
        issue(pmmd_pkg::OP_LOAD,  16'h4000, 8'h55);
        issue(pmmd_pkg::OP_LOAD,  16'hFFFF, 8'hFF);
        issue(pmmd_pkg::OP_CLEAR, 16'hFFFF, 8'hFF);
        issue(pmmd_pkg::OP_READ,  16'h0000, 8'h00);
        issue(pmmd_pkg::OP_WRITE, 16'h0001, 8'h5A);
        issue(pmmd_pkg::OP_READ,  16'h0000, 8'h00);
        random_batch(150);

        // fill, rom, mirror into rom, mirror into fill
        set_region(0, 16'h1000, 17'h001F0, pmmd_pkg::KIND_FILL,   16'h01A5);
        set_region(1, 16'h8000, 17'h01000, pmmd_pkg::KIND_ROM,    16'h0800);
        set_region(2, 16'h4000, 17'h00100, pmmd_pkg::KIND_MIRROR, 16'h8010);
        set_region(3, 16'h5000, 17'h00200, pmmd_pkg::KIND_MIRROR, 16'h1080);
        issue(pmmd_pkg::OP_LOAD,  16'h0010, 8'h77);
        issue(pmmd_pkg::OP_READ,  16'h4000, 8'h00);
        issue(pmmd_pkg::OP_READ,  16'h8900, 8'h00);
        issue(pmmd_pkg::OP_READ,  16'h11F5, 8'h00);
        issue(pmmd_pkg::OP_WRITE, 16'h1000, 8'h33);
        issue(pmmd_pkg::OP_READ,  16'h1000, 8'h00);
        issue(pmmd_pkg::OP_WRITE, 16'h8000, 8'h44);
        issue(pmmd_pkg::OP_READ,  16'h5000, 8'h00);
        issue(pmmd_pkg::OP_READ,  16'h5180, 8'h00);
        issue(pmmd_pkg::OP_READ,  16'h4100, 8'h00);
        random_batch(250);

        // extremes: oversize walk, page wrap, clash, mirror to fill
        write_reg(0, 33'h1_FFFF_FFFF);
        write_reg(1, 33'h3FFFF);
        set_region(1, 16'hFF80, 17'h00100, pmmd_pkg::KIND_FILL,   16'h0000);
        set_region(2, 16'h0000, 17'h00200, pmmd_pkg::KIND_ROM,    16'h3FFF);
        set_region(3, 16'h2000, 17'h00100, pmmd_pkg::KIND_MIRROR, 16'hFF90);
        issue(pmmd_pkg::OP_READ,  16'hFFFF, 8'h00);
        issue(pmmd_pkg::OP_READ,  16'h0010, 8'h00);
        issue(pmmd_pkg::OP_READ,  16'h2000, 8'h00);
        issue(pmmd_pkg::OP_WRITE, 16'h0010, 8'h99);
        random_batch(150);

        // mirror onto mirror, full-size rom, zero length
        set_region(0, 16'h6000, 17'h00100, pmmd_pkg::KIND_MIRROR, 16'h7000);
        set_region(1, 16'h7000, 17'h00100, pmmd_pkg::KIND_MIRROR, 16'h0000);
        set_region(2, 16'hC000, 17'h04000, pmmd_pkg::KIND_ROM,    16'h4000);
        set_region(3, 16'h3000, 17'h00000, pmmd_pkg::KIND_FILL,   16'hFFFF);
        issue(pmmd_pkg::OP_READ,  16'h6000, 8'h00);
        issue(pmmd_pkg::OP_WRITE, 16'h6001, 8'h12);
        issue(pmmd_pkg::OP_READ,  16'h3000, 8'h00);
        random_batch(150);

        steady = 1'b1;
        random_config();
        random_batch(150);
        steady = 1'b0;
        repeat (4) begin
            random_config();
            random_batch(100);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
